// ===== rtl/core/exact_pattern_stream_matcher_assert.svh =====
// Assertion macros for the exact pattern stream matcher.
// Included by the modules that carry concurrent checks; no other dependency.
`ifndef EXACT_PATTERN_STREAM_MATCHER_ASSERT_SVH
`define EXACT_PATTERN_STREAM_MATCHER_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define EPSM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define EPSM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define EPSM_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define EPSM_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== rtl/core/epsm_pkg.sv =====
// Shared constants, register codes and types of the exact pattern stream matcher.
// No dependencies; every other file of the block but the assert header uses it.
`timescale 1ns / 1ps

package epsm_pkg;

   localparam int MAX_PATTERN = 32;
   localparam int MIN_PATTERN = 2;
   localparam int BYTE_W      = 8;
   localparam int WORD_W      = 64;
   localparam int PAT_WORDS   = 4;
   localparam int PAT_BYTES   = PAT_WORDS * WORD_W / BYTE_W;
   localparam int LEN_REG_W   = 6;
   localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
   localparam int IDX_W       = $clog2(MAX_PATTERN);
   localparam int OFFSET_W    = 32;
   localparam int CSR_IDX_W   = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LENGTH = 3'd0,
      CSR_WORD0  = 3'd1,
      CSR_WORD1  = 3'd2,
      CSR_WORD2  = 3'd3,
      CSR_WORD3  = 3'd4
   } csr_index_type;

   typedef logic [BYTE_W-1:0] text_byte_type;

   // Active pattern: clamped length plus bytes, byte 0 first.
   typedef struct packed {
      logic [LEN_W-1:0]                        length;
      logic [MAX_PATTERN-1:0][BYTE_W-1:0]      pattern;
   } cfg_type;

   // Window as seen by the incoming byte: index 0 is that byte.
   typedef struct packed {
      logic [MAX_PATTERN-1:0][BYTE_W-1:0]      bytes;
      logic [LEN_W-1:0]                        held;
      logic [OFFSET_W-1:0]                     offset;
   } win_type;

   typedef struct packed {
      logic                 found;
      logic [OFFSET_W-1:0]  match_start;
      logic                 text_done;
   } rsp_data_type;

endpackage

// ===== rtl/core/epsm_req_if.sv =====
// Request channel of the matcher: one text byte and its end-of-text flag.
// Depends on epsm_pkg.
`timescale 1ns / 1ps

interface epsm_req_if;
   logic                  valid;
   logic                  ready;
   logic [epsm_pkg::BYTE_W-1:0] text_byte;
   logic                  end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

// ===== rtl/core/epsm_rsp_if.sv =====
// Result channel of the matcher: match flag, start offset and text-closed flag.
// Depends on epsm_pkg.
`timescale 1ns / 1ps

interface epsm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          found;
   logic [epsm_pkg::OFFSET_W-1:0] match_start;
   logic                          text_done;

   modport source (output valid, output found, output match_start, output text_done,
                   input ready);
   modport sink   (input valid, input found, input match_start, input text_done,
                   output ready);
endinterface

// ===== rtl/core/epsm_csr_if.sv =====
// Register write channel of the matcher: register index and write data.
// Depends on epsm_pkg.
`timescale 1ns / 1ps

interface epsm_csr_if;
   logic                           valid;
   logic                           ready;
   logic [epsm_pkg::CSR_IDX_W-1:0] index;
   logic [epsm_pkg::WORD_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/epsm_csr.sv =====
// Pattern length and pattern word registers, plus the clamped active pattern.
// Depends on epsm_pkg and epsm_csr_if.
`timescale 1ns / 1ps

module epsm_csr (
   input  logic                 clock,
   input  logic                 reset,
   epsm_csr_if.sink             csr_ch,
   output epsm_pkg::cfg_type    cfg
);

   logic [epsm_pkg::LEN_REG_W-1:0]                     length_ff, length_in;
   logic [epsm_pkg::PAT_WORDS-1:0][epsm_pkg::WORD_W-1:0] word_ff, word_in;
   logic [epsm_pkg::PAT_BYTES-1:0][epsm_pkg::BYTE_W-1:0] pat_bytes;
   logic                                               csr_fire;

   assign csr_ch.ready = 1'b1;
   assign csr_fire     = csr_ch.valid;

   always_comb begin
      length_in = length_ff;
      word_in   = word_ff;
      if (csr_fire) begin
         case (csr_ch.index)
            epsm_pkg::CSR_LENGTH: length_in  = csr_ch.data[epsm_pkg::LEN_REG_W-1:0];
            epsm_pkg::CSR_WORD0:  word_in[0] = csr_ch.data;
            epsm_pkg::CSR_WORD1:  word_in[1] = csr_ch.data;
            epsm_pkg::CSR_WORD2:  word_in[2] = csr_ch.data;
            epsm_pkg::CSR_WORD3:  word_in[3] = csr_ch.data;
            default: ;  // writes past the register list are dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= epsm_pkg::LEN_REG_W'(epsm_pkg::MIN_PATTERN);
         word_ff   <= '0;
      end else begin
         length_ff <= length_in;
         word_ff   <= word_in;
      end
   end

   assign pat_bytes = word_ff;

   always_comb begin
      if (length_ff < epsm_pkg::LEN_REG_W'(epsm_pkg::MIN_PATTERN)) begin
         cfg.length = epsm_pkg::LEN_W'(epsm_pkg::MIN_PATTERN);
      end else if (32'(length_ff) > 32'(epsm_pkg::MAX_PATTERN)) begin
         cfg.length = epsm_pkg::LEN_W'(epsm_pkg::MAX_PATTERN);
      end else begin
         cfg.length = epsm_pkg::LEN_W'(length_ff);
      end
      for (int i = 0; i < epsm_pkg::MAX_PATTERN; i++) begin
         // bytes beyond the four words read as zero
         if (i < epsm_pkg::PAT_BYTES) begin
            cfg.pattern[i] = pat_bytes[i];
         end else begin
            cfg.pattern[i] = '0;
         end
      end
   end

endmodule

// ===== rtl/core/epsm_window.sv =====
// Sliding byte window, fill count and text offset of the current text.
// Depends on epsm_pkg.
`timescale 1ns / 1ps

module epsm_window (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  epsm_pkg::text_byte_type text_byte,
   input  logic                    end_of_text,
   output epsm_pkg::win_type       win
);

   logic [epsm_pkg::MAX_PATTERN-1:0][epsm_pkg::BYTE_W-1:0] bytes_ff, bytes_in;
   logic [epsm_pkg::LEN_W-1:0]                              held_ff, held_in;
   logic [epsm_pkg::OFFSET_W-1:0]                           offset_ff, offset_in;

   // View of the window with the incoming byte already shifted in.
   always_comb begin
      win.bytes[0] = text_byte;
      for (int k = 1; k < epsm_pkg::MAX_PATTERN; k++) begin
         win.bytes[k] = bytes_ff[k-1];
      end
      if (held_ff == epsm_pkg::LEN_W'(epsm_pkg::MAX_PATTERN)) begin
         win.held = held_ff;
      end else begin
         win.held = held_ff + 1'b1;
      end
      win.offset = offset_ff;
   end

   // Stale bytes past the fill count never count toward a hit, so end of text
   // only clears the count and the offset.
   always_comb begin
      bytes_in  = bytes_ff;
      held_in   = held_ff;
      offset_in = offset_ff;
      if (accept) begin
         bytes_in = win.bytes;
         if (end_of_text) begin
            held_in   = '0;
            offset_in = '0;
         end else begin
            held_in = win.held;
            if (offset_ff != '1) begin
               offset_in = offset_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
      if (reset) begin
         held_ff   <= '0;
         offset_ff <= '0;
      end else begin
         held_ff   <= held_in;
         offset_ff <= offset_in;
      end
   end

endmodule

// ===== rtl/core/epsm_match.sv =====
// Parallel compare of the active pattern against the newest window bytes,
// and the start offset of a hit. Depends on epsm_pkg.
`timescale 1ns / 1ps

module epsm_match (
   input  epsm_pkg::cfg_type      cfg,
   input  epsm_pkg::win_type      win,
   output logic                   hit,
   output logic [epsm_pkg::OFFSET_W-1:0] start
);

   logic [epsm_pkg::MAX_PATTERN-1:0] lane_ok;
   logic [epsm_pkg::LEN_W-1:0]       len_m1;
   logic [epsm_pkg::LEN_W-1:0]       pat_idx [epsm_pkg::MAX_PATTERN];
   logic [epsm_pkg::OFFSET_W-1:0]    span;

   assign len_m1 = cfg.length - 1'b1;

   // Window byte k lines up with pattern byte length-1-k.
   always_comb begin
      for (int k = 0; k < epsm_pkg::MAX_PATTERN; k++) begin
         pat_idx[k] = len_m1 - epsm_pkg::LEN_W'(k);
         if (epsm_pkg::LEN_W'(k) >= cfg.length) begin
            lane_ok[k] = 1'b1;
         end else begin
            lane_ok[k] = (win.bytes[k] == cfg.pattern[pat_idx[k][epsm_pkg::IDX_W-1:0]]);
         end
      end
   end

   assign hit  = (&lane_ok) && (win.held >= cfg.length);
   assign span = epsm_pkg::OFFSET_W'(len_m1);

   always_comb begin
      if (!hit) begin
         start = '0;
      end else if (win.offset >= span) begin
         start = win.offset - span;
      end else begin
         start = '0;
      end
   end

endmodule

// ===== rtl/core/exact_pattern_stream_matcher.sv =====
// Exact pattern stream matcher, top level. Depends on epsm_pkg, the three
// channel interfaces, epsm_csr, epsm_window, epsm_match and the assert header.
`timescale 1ns / 1ps
`include "exact_pattern_stream_matcher_assert.svh"

// Scans a byte stream for a pattern of 2 to 32 bytes set through the register
// port (register 0 the length, registers 1 to 4 the pattern bytes, byte 0 in
// the low bits of register 1) and returns a result when an occurrence ends at
// the current byte or when the byte carries end of text; other bytes give no
// result. One byte is taken every clock cycle unless the result channel stalls:
// each byte is shifted into a 32-byte window and compared against all active
// pattern bytes at once, and its result is registered in the output register
// in the cycle after the request is taken. The output register is the only
// buffer, so a stalled result channel holds off new requests until that result
// is taken. Offsets count from the first byte of each text and stop at all ones;
// end of text restarts them. Change registers only while no request is in flight.
module exact_pattern_stream_matcher (
   input  logic          clock,
   input  logic          reset,
   epsm_req_if.sink      req_ch,
   epsm_rsp_if.source    rsp_ch,
   epsm_csr_if.sink      csr_ch
);

   epsm_pkg::cfg_type       cfg;
   epsm_pkg::win_type       win;
   epsm_pkg::rsp_data_type  rsp_data_ff, rsp_data_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    req_fire;
   logic                    hit;
   logic [epsm_pkg::OFFSET_W-1:0] start;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_fire     = req_ch.valid && req_ch.ready;

   epsm_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   epsm_window u_window (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_fire),
      .text_byte   (req_ch.text_byte),
      .end_of_text (req_ch.end_of_text),
      .win         (win)
   );

   epsm_match u_match (
      .cfg   (cfg),
      .win   (win),
      .hit   (hit),
      .start (start)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (req_fire) begin
         rsp_valid_in            = hit || req_ch.end_of_text;
         rsp_data_in.found       = hit;
         rsp_data_in.match_start = start;
         rsp_data_in.text_done   = req_ch.end_of_text;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.found       = rsp_data_ff.found;
   assign rsp_ch.match_start = rsp_data_ff.match_start;
   assign rsp_ch.text_done   = rsp_data_ff.text_done;

   `EPSM_ASSERT_IMP(a_no_overwrite, clock, reset, rsp_valid_ff && !rsp_ch.ready, !req_fire, "request taken over a pending result")
   `EPSM_ASSERT_NEXT(a_eot_restart, clock, reset, req_fire && req_ch.end_of_text, win.offset == '0, "offset not restarted after end of text")
   `EPSM_ASSERT_NEXT(a_offset_sat, clock, reset, req_fire && !req_ch.end_of_text && (win.offset == '1), win.offset == '1, "offset wrapped past saturation")

endmodule
